>>> src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SLGC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slgc assertion failed");
`define SLGC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("slgc assertion failed");
`else
`define SLGC_ASSERT(lbl, clk, rst_n, prop)
`define SLGC_ASSERT_NR(lbl, clk, prop)
`endif

`endif

>>> src/slgc_pkg.sv
package slgc_pkg;

    localparam int MAX_TAGS  = 64;
    localparam int LINE_BITS = 24;
    localparam int TAG_W     = $clog2(MAX_TAGS + 1);
    localparam int ADDR_W    = $clog2(MAX_TAGS);
    localparam int COL_W     = 6;
    localparam int FUNC_W    = 4;
    localparam int EV_W      = 4;
    localparam int CODE_W    = 4;
    localparam int KIND_W    = 3;
    localparam int VT_W      = 24;
    localparam int NSLOT     = 3;

    localparam logic [VT_W-1:0] VT_MAX = '1;

    // token kinds
    localparam logic [FUNC_W-1:0] FN_END    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_LEXERR = 4'd1;
    localparam logic [FUNC_W-1:0] FN_COMM   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DATA   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_LOOP   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_STOP   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_TAG    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_VAL_SQ = 4'd7;
    localparam logic [FUNC_W-1:0] FN_VAL_DQ = 4'd8;
    localparam logic [FUNC_W-1:0] FN_VAL_SC = 4'd9;
    localparam logic [FUNC_W-1:0] FN_VAL_FC = 4'd10;
    localparam logic [FUNC_W-1:0] FN_VAL_BV = 4'd11;

    // event kinds
    localparam logic [EV_W-1:0] EV_COMMENT   = 4'd0;
    localparam logic [EV_W-1:0] EV_STARTDATA = 4'd1;
    localparam logic [EV_W-1:0] EV_ENDDATA   = 4'd2;
    localparam logic [EV_W-1:0] EV_STARTLOOP = 4'd3;
    localparam logic [EV_W-1:0] EV_ENDLOOP   = 4'd4;
    localparam logic [EV_W-1:0] EV_VALUE     = 4'd5;
    localparam logic [EV_W-1:0] EV_ERROR     = 4'd6;
    localparam logic [EV_W-1:0] EV_WARNING   = 4'd7;
    localparam logic [EV_W-1:0] EV_FATAL     = 4'd8;

    // diagnostics
    localparam logic [CODE_W-1:0] DG_NONE       = 4'd0;
    localparam logic [CODE_W-1:0] DG_FILE_LOOP  = 4'd1;
    localparam logic [CODE_W-1:0] DG_FILE_STOP  = 4'd2;
    localparam logic [CODE_W-1:0] DG_FILE_TAG   = 4'd3;
    localparam logic [CODE_W-1:0] DG_FILE_VAL   = 4'd4;
    localparam logic [CODE_W-1:0] DG_DATA_AGAIN = 4'd5;
    localparam logic [CODE_W-1:0] DG_VAL_EXP    = 4'd6;
    localparam logic [CODE_W-1:0] DG_NO_TAGS    = 4'd7;
    localparam logic [CODE_W-1:0] DG_VAL_UNEXP  = 4'd8;
    localparam logic [CODE_W-1:0] DG_NO_VALS    = 4'd9;
    localparam logic [CODE_W-1:0] DG_TAG_OVF    = 4'd10;
    localparam logic [CODE_W-1:0] DG_KEYWORD    = 4'd11;
    localparam logic [CODE_W-1:0] DG_COUNT      = 4'd12;
    localparam logic [CODE_W-1:0] DG_BAD_KIND   = 4'd13;

    typedef struct packed {
        logic [EV_W-1:0]      ev;
        logic [CODE_W-1:0]    code;
        logic [LINE_BITS-1:0] line;
    } t_slot;

    // events of one token, value event always in the last filled slot
    typedef struct packed {
        logic [1:0]             cnt;
        t_slot [NSLOT-1:0]      slot;
        logic [COL_W-1:0]       col;
        logic                   looped;
        logic [KIND_W-1:0]      kind;
        logic                   tl_mem;
        logic [LINE_BITS-1:0]   tl_fix;
    } t_desc;

endpackage

>>> src/slgc_ram.sv
module slgc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/slgc_track.sv
`include "assert_macros.svh"

module slgc_track
    import slgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [LINE_BITS-1:0] i_line,
    input  logic                 i_kw,
    output t_desc                o_desc,
    output logic                 o_wr_en,
    output logic [ADDR_W-1:0]    o_wr_addr,
    output logic [LINE_BITS-1:0] o_wr_data,
    output logic                 o_rd_en,
    output logic [ADDR_W-1:0]    o_rd_addr
);

    logic                 r_block, n_block;
    logic                 r_halted, n_halted;
    logic                 r_loop, n_loop;
    logic                 r_header, n_header;
    logic                 r_pending, n_pending;
    logic [TAG_W-1:0]     r_tt, n_tt;
    logic [VT_W-1:0]      r_vt, n_vt;
    logic [TAG_W-1:0]     r_rem, n_rem;
    logic [TAG_W-1:0]     r_next_col, n_next_col;
    logic                 r_row_vld, n_row_vld;
    logic [LINE_BITS-1:0] r_row, n_row;
    logic                 r_wrap_vld, n_wrap_vld;
    logic [LINE_BITS-1:0] r_wrap, n_wrap;
    logic [LINE_BITS-1:0] r_free_line, n_free_line;

    logic [NSLOT-1:0]     c_en;
    logic [EV_W-1:0]      c_ev   [NSLOT];
    logic [CODE_W-1:0]    c_code [NSLOT];
    logic [LINE_BITS-1:0] c_line [NSLOT];
    logic                 do_close;
    logic                 wr_req, rd_req;
    logic [TAG_W-1:0]     new_col, rem_inc;
    logic [1:0]           k;
    t_desc                d;

    assign new_col = (r_next_col >= r_tt) ? '0 : r_next_col;
    assign rem_inc = r_rem + TAG_W'(1);

    always_comb begin
        n_block     = r_block;
        n_halted    = r_halted;
        n_loop      = r_loop;
        n_header    = r_header;
        n_pending   = r_pending;
        n_tt        = r_tt;
        n_vt        = r_vt;
        n_rem       = r_rem;
        n_next_col  = r_next_col;
        n_row_vld   = r_row_vld;
        n_row       = r_row;
        n_wrap_vld  = r_wrap_vld;
        n_wrap      = r_wrap;
        n_free_line = r_free_line;
        c_en        = '0;
        for (int i = 0; i < NSLOT; i++) begin
            c_ev[i]   = EV_ERROR;
            c_code[i] = DG_NONE;
            c_line[i] = i_line;
        end
        do_close = 1'b0;
        wr_req   = 1'b0;
        rd_req   = 1'b0;
        d        = '0;

        if (!r_halted) begin
            if (i_func == FN_END) begin
                c_en[2]  = 1'b1;
                c_ev[2]  = EV_ENDDATA;
                n_halted = 1'b1;
            end else if (i_func == FN_LEXERR) begin
                c_en[2]  = 1'b1;
                c_ev[2]  = EV_FATAL;
                n_halted = 1'b1;
            end else if (i_func == FN_COMM) begin
                c_en[2] = 1'b1;
                c_ev[2] = EV_COMMENT;
            end else if (!r_block) begin
                c_en[2] = 1'b1;
                if (i_func == FN_DATA) begin
                    c_ev[2]    = EV_STARTDATA;
                    n_block    = 1'b1;
                    n_loop     = 1'b0;
                    n_header   = 1'b1;
                    n_pending  = 1'b0;
                    n_vt       = '0;
                    n_rem      = '0;
                    n_next_col = '0;
                    n_row_vld  = 1'b0;
                    n_wrap_vld = 1'b0;
                end else begin
                    case (i_func)
                        FN_LOOP:   c_code[2] = DG_FILE_LOOP;
                        FN_STOP:   c_code[2] = DG_FILE_STOP;
                        FN_TAG:    c_code[2] = DG_FILE_TAG;
                        FN_VAL_SQ, FN_VAL_DQ, FN_VAL_SC, FN_VAL_FC, FN_VAL_BV:
                            c_code[2] = DG_FILE_VAL;
                        default:   c_code[2] = DG_BAD_KIND;
                    endcase
                end
            end else if (i_func == FN_LOOP) begin
                c_en[0]    = r_pending;
                c_code[0]  = DG_VAL_EXP;
                c_en[2]    = 1'b1;
                c_ev[2]    = EV_STARTLOOP;
                n_vt       = '0;
                n_rem      = '0;
                n_next_col = '0;
                n_row_vld  = 1'b0;
                n_wrap_vld = 1'b0;
                n_loop     = 1'b1;
                n_header   = 1'b1;
                n_tt       = '0;
            end else if (i_func == FN_STOP) begin
                n_loop   = 1'b0;
                do_close = 1'b1;
            end else if (i_func == FN_TAG) begin
                n_free_line = i_line;
                if (r_loop) begin
                    if (r_header) begin
                        if (r_tt < TAG_W'(MAX_TAGS)) begin
                            wr_req = 1'b1;
                            n_tt   = r_tt + TAG_W'(1);
                        end else begin
                            c_en[2]   = 1'b1;
                            c_code[2] = DG_TAG_OVF;
                        end
                    end else begin
                        n_loop    = 1'b0;
                        do_close  = 1'b1;
                        n_pending = 1'b1;
                    end
                end else begin
                    c_en[2]   = r_pending;
                    c_code[2] = DG_VAL_EXP;
                    n_pending = 1'b1;
                end
            end else if (i_func >= FN_VAL_SQ && i_func <= FN_VAL_BV) begin
                if (r_loop) begin
                    c_en[0]    = (r_tt == '0);
                    c_code[0]  = DG_NO_TAGS;
                    n_header   = 1'b0;
                    if (r_vt != VT_MAX) begin
                        n_vt  = r_vt + VT_W'(1);
                        n_rem = (rem_inc == r_tt) ? '0 : rem_inc;
                    end
                    n_next_col = new_col + TAG_W'(1);
                    if (r_next_col >= r_tt && (!r_row_vld || r_row < i_line)) begin
                        if (!r_wrap_vld) begin
                            n_wrap_vld = 1'b1;
                            n_wrap     = i_line;
                        end
                        n_row_vld = 1'b1;
                        n_row     = i_line;
                    end
                    d.col    = new_col[COL_W-1:0];
                    d.looped = 1'b1;
                    d.tl_mem = (r_tt != '0);
                    rd_req   = (r_tt != '0);
                end else begin
                    c_en[0]   = !r_pending;
                    c_code[0] = DG_VAL_UNEXP;
                    n_pending = 1'b0;
                    d.tl_fix  = r_free_line;
                end
                c_en[1]   = i_kw;
                c_ev[1]   = EV_WARNING;
                c_code[1] = DG_KEYWORD;
                c_en[2]   = 1'b1;
                c_ev[2]   = EV_VALUE;
                d.kind    = KIND_W'(i_func - FN_VAL_SQ);
            end else begin
                c_en[2]   = 1'b1;
                c_code[2] = (i_func == FN_DATA) ? DG_DATA_AGAIN : DG_BAD_KIND;
            end

            if (do_close) begin
                c_en[0]   = (r_vt == '0);
                c_code[0] = DG_NO_VALS;
                c_en[1]   = (r_tt != '0) && (r_rem != '0);
                c_ev[1]   = EV_WARNING;
                c_code[1] = DG_COUNT;
                c_line[1] = r_wrap_vld ? r_wrap : i_line;
                c_en[2]   = 1'b1;
                c_ev[2]   = EV_ENDLOOP;
            end
        end

        // pack enabled events in order
        k = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (c_en[i]) begin
                d.slot[k].ev   = c_ev[i];
                d.slot[k].code = c_code[i];
                d.slot[k].line = c_line[i];
                k = k + 2'd1;
            end
        end
        d.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block     <= 1'b0;
            r_halted    <= 1'b0;
            r_loop      <= 1'b0;
            r_header    <= 1'b1;
            r_pending   <= 1'b0;
            r_tt        <= '0;
            r_vt        <= '0;
            r_rem       <= '0;
            r_next_col  <= '0;
            r_row_vld   <= 1'b0;
            r_wrap_vld  <= 1'b0;
            r_free_line <= '0;
        end else if (i_take) begin
            r_block     <= n_block;
            r_halted    <= n_halted;
            r_loop      <= n_loop;
            r_header    <= n_header;
            r_pending   <= n_pending;
            r_tt        <= n_tt;
            r_vt        <= n_vt;
            r_rem       <= n_rem;
            r_next_col  <= n_next_col;
            r_row_vld   <= n_row_vld;
            r_wrap_vld  <= n_wrap_vld;
            r_free_line <= n_free_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_row  <= n_row;
            r_wrap <= n_wrap;
        end
    end

    // a tag line is written one token before any value can read it
    assign o_desc    = d;
    assign o_wr_en   = i_take && wr_req;
    assign o_wr_addr = r_tt[ADDR_W-1:0];
    assign o_wr_data = i_line;
    assign o_rd_en   = i_take && rd_req;
    assign o_rd_addr = new_col[ADDR_W-1:0];

    `SLGC_ASSERT(a_halt_sticks, i_clk, i_rst_n, r_halted |=> r_halted)
    `SLGC_ASSERT(a_tag_bound, i_clk, i_rst_n, (r_tt <= TAG_W'(MAX_TAGS)) && (r_next_col <= TAG_W'(MAX_TAGS)))

endmodule

>>> src/slgc_emit.sv
`include "assert_macros.svh"

module slgc_emit
    import slgc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  t_desc                i_desc,
    input  logic [LINE_BITS-1:0] i_rd_data,
    input  logic                 i_m_ready,
    output logic                 o_ready,
    output logic                 o_m_valid,
    output logic [EV_W-1:0]      o_m_ev,
    output logic [CODE_W-1:0]    o_m_code,
    output logic [LINE_BITS-1:0] o_m_line,
    output logic [COL_W-1:0]     o_m_col,
    output logic [LINE_BITS-1:0] o_m_tag_line,
    output logic                 o_m_looped,
    output logic [KIND_W-1:0]    o_m_kind,
    output logic                 o_m_last
);

    logic                 r_b_valid;
    t_desc                r_b;
    logic [1:0]           r_idx;
    logic                 r_m_valid;
    logic [EV_W-1:0]      r_m_ev;
    logic [CODE_W-1:0]    r_m_code;
    logic [LINE_BITS-1:0] r_m_line;
    logic [COL_W-1:0]     r_m_col;
    logic [LINE_BITS-1:0] r_m_tag_line;
    logic                 r_m_looped;
    logic [KIND_W-1:0]    r_m_kind;
    logic                 r_m_last;

    logic  out_load, send, is_final, b_done, is_val;
    t_slot cur;

    assign out_load = !r_m_valid || i_m_ready;
    assign send     = r_b_valid && out_load;
    assign is_final = (r_idx == r_b.cnt - 2'd1);
    assign b_done   = send && is_final;
    assign o_ready  = !r_b_valid || b_done;
    assign cur      = r_b.slot[r_idx];
    assign is_val   = (cur.ev == EV_VALUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_take && i_desc.cnt != '0) begin
                r_b_valid <= 1'b1;
                r_idx     <= '0;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end else if (send) begin
                r_idx <= r_idx + 2'd1;
            end
            if (send) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_b <= i_desc;
        end
        if (send) begin
            r_m_ev       <= cur.ev;
            r_m_code     <= cur.code;
            r_m_line     <= cur.line;
            r_m_col      <= is_val ? r_b.col : '0;
            r_m_tag_line <= !is_val ? '0 : (r_b.tl_mem ? i_rd_data : r_b.tl_fix);
            r_m_looped   <= is_val && r_b.looped;
            r_m_kind     <= is_val ? r_b.kind : '0;
            r_m_last     <= is_final;
        end
    end

    assign o_m_valid    = r_m_valid;
    assign o_m_ev       = r_m_ev;
    assign o_m_code     = r_m_code;
    assign o_m_line     = r_m_line;
    assign o_m_col      = r_m_col;
    assign o_m_tag_line = r_m_tag_line;
    assign o_m_looped   = r_m_looped;
    assign o_m_kind     = r_m_kind;
    assign o_m_last     = r_m_last;

    `SLGC_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_b_valid |-> (r_b.cnt != '0 && r_idx < r_b.cnt))
    `SLGC_ASSERT(a_no_overwrite, i_clk, i_rst_n, (i_take && r_b_valid) |-> b_done)
    `SLGC_ASSERT(a_value_final, i_clk, i_rst_n, (r_m_valid && r_m_ev == EV_VALUE) |-> r_m_last)

endmodule

>>> src/star_loop_grammar_checker_core.sv
// star/cif loop grammar checker
// input stream: one classified token per word. s_axis_tdata carries the source
// line, s_axis_tuser the token kind and the keyword flag.
// output stream: one event per word, up to three per token; m_axis_tlast marks
// the final event of a token. tokens after end of input or a lexer error are
// accepted and give no event.
// path: the tag line memory read and the event stage load on the edge that
// accepts a token; the first event of the token then passes from the event
// stage into the output register.
// throughput: one token per cycle while each token gives one event and the
// receiver is ready; a token with more events holds the single event stage,
// which feeds the output register, until its last event is sent.
// reset (synchronous, i_rst_n low) returns to file level with no loop open
// and clears the counters; the tag line memory is not cleared.
// when the receiver stalls the output register holds its word, the event
// stage keeps one more token, and s_axis_tready falls once that token cannot
// finish in the current cycle.
module star_loop_grammar_checker_core
    import slgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // src_line
    input  logic [4:0]  s_axis_tuser,  // func, keyword_seen
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // code, event_line, column, tag_line, zero pad
    output logic [7:0]  m_axis_tuser,  // event_res, looped, value_kind
    output logic        m_axis_tlast
);

    logic                 take;
    logic                 ready;
    t_desc                desc;
    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [LINE_BITS-1:0] wr_data, rd_data;
    logic [EV_W-1:0]      m_ev;
    logic [CODE_W-1:0]    m_code;
    logic [LINE_BITS-1:0] m_line;
    logic [COL_W-1:0]     m_col;
    logic [LINE_BITS-1:0] m_tag_line;
    logic                 m_looped;
    logic [KIND_W-1:0]    m_kind;

    assign take          = s_axis_tvalid && ready;
    assign s_axis_tready = ready;

    slgc_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_func    (s_axis_tuser[3:0]),
        .i_line    (s_axis_tdata),
        .i_kw      (s_axis_tuser[4]),
        .o_desc    (desc),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    slgc_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_TAGS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    slgc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_desc       (desc),
        .i_rd_data    (rd_data),
        .i_m_ready    (m_axis_tready),
        .o_ready      (ready),
        .o_m_valid    (m_axis_tvalid),
        .o_m_ev       (m_ev),
        .o_m_code     (m_code),
        .o_m_line     (m_line),
        .o_m_col      (m_col),
        .o_m_tag_line (m_tag_line),
        .o_m_looped   (m_looped),
        .o_m_kind     (m_kind),
        .o_m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, m_tag_line, m_col, m_line, m_code};
    assign m_axis_tuser = {m_kind, m_looped, m_ev};

endmodule

>>> tb/star_loop_grammar_checker_core_tb.sv
`timescale 1ns / 100ps

module star_loop_grammar_checker_core_tb;
    import slgc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [FUNC_W-1:0]    fn;
        logic [LINE_BITS-1:0] ln;
        logic                 kw;
        bit                   hold;
    } t_token;

    typedef struct {
        logic [EV_W-1:0]      ev;
        logic [CODE_W-1:0]    code;
        logic [LINE_BITS-1:0] ln;
        logic [COL_W-1:0]     col;
        logic [LINE_BITS-1:0] tl;
        logic                 looped;
        logic [KIND_W-1:0]    kind;
        logic                 last;
    } t_gram_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    t_token      pending_tokens[$];
    t_gram_event grammar_events_q[$];

    int fail_cnt = 0;
    int tokens_total = 0;
    int tokens_taken = 0;
    int words_seen = 0;
    int ev_hits[9];
    int cyc = 0;
    int tx_gap = 0;
    int tx_pct = 25;
    int rx_stall = 0;
    int rx_pct = 25;
    bit long_hold_done = 1'b0;
    bit hold_next = 1'b0;
    logic [LINE_BITS-1:0] cur_ln = '0;

    // grammar tracker state
    bit     st_block = 1'b0;
    bit     st_halt = 1'b0;
    bit     st_loop = 1'b0;
    bit     st_hdr = 1'b1;
    bit     st_pend = 1'b0;
    int     st_tags = 0;
    int     st_vals = 0;
    int     st_col = -1;
    longint st_row = -1;
    longint st_wrap = -1;
    logic [LINE_BITS-1:0] st_free_tl = '0;
    logic [LINE_BITS-1:0] st_tag_ln[MAX_TAGS];

    star_loop_grammar_checker_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic void add_event(logic [EV_W-1:0] ev, logic [CODE_W-1:0] dg,
                                      logic [LINE_BITS-1:0] ln, int col,
                                      logic [LINE_BITS-1:0] tl, logic lp,
                                      logic [KIND_W-1:0] kd);
        t_gram_event e;
        e.ev = ev;
        e.code = dg;
        e.ln = ln;
        e.col = COL_W'(col);
        e.tl = tl;
        e.looped = lp;
        e.kind = kd;
        e.last = 1'b0;
        grammar_events_q = {grammar_events_q, e};
    endfunction

    function automatic void close_grammar_loop(logic [LINE_BITS-1:0] ln);
        if (st_vals < 1)
            add_event(EV_ERROR, DG_NO_VALS, ln, 0, '0, 1'b0, '0);
        if (st_tags != 0 && (st_vals % st_tags) != 0)
            add_event(EV_WARNING, DG_COUNT, (st_wrap < 0) ? ln : st_wrap[LINE_BITS-1:0],
                      0, '0, 1'b0, '0);
        add_event(EV_ENDLOOP, DG_NONE, ln, 0, '0, 1'b0, '0);
    endfunction

    task automatic track_grammar(input logic [FUNC_W-1:0] fn,
                                 input logic [LINE_BITS-1:0] ln, input logic kw);
        int first;
        int col;
        logic [LINE_BITS-1:0] tl;
        logic [CODE_W-1:0] dg;
        first = grammar_events_q.size();
        if (st_halt)
            return;
        if (fn == FN_END) begin
            add_event(EV_ENDDATA, DG_NONE, ln, 0, '0, 1'b0, '0);
            st_halt = 1'b1;
        end else if (fn == FN_LEXERR) begin
            add_event(EV_FATAL, DG_NONE, ln, 0, '0, 1'b0, '0);
            st_halt = 1'b1;
        end else if (fn == FN_COMM) begin
            add_event(EV_COMMENT, DG_NONE, ln, 0, '0, 1'b0, '0);
        end else if (!st_block) begin
            if (fn == FN_DATA) begin
                add_event(EV_STARTDATA, DG_NONE, ln, 0, '0, 1'b0, '0);
                st_block = 1'b1;
                st_loop = 1'b0;
                st_hdr = 1'b1;
                st_pend = 1'b0;
                st_vals = 0;
                st_col = -1;
                st_row = -1;
                st_wrap = -1;
            end else begin
                case (fn)
                    FN_LOOP: dg = DG_FILE_LOOP;
                    FN_STOP: dg = DG_FILE_STOP;
                    FN_TAG:  dg = DG_FILE_TAG;
                    default: dg = (fn <= FN_VAL_BV) ? DG_FILE_VAL : DG_BAD_KIND;
                endcase
                add_event(EV_ERROR, dg, ln, 0, '0, 1'b0, '0);
            end
        end else if (fn == FN_LOOP) begin
            if (st_pend)
                add_event(EV_ERROR, DG_VAL_EXP, ln, 0, '0, 1'b0, '0);
            st_vals = 0;
            st_col = -1;
            st_row = -1;
            st_wrap = -1;
            st_loop = 1'b1;
            st_hdr = 1'b1;
            st_tags = 0;
            add_event(EV_STARTLOOP, DG_NONE, ln, 0, '0, 1'b0, '0);
        end else if (fn == FN_STOP) begin
            st_loop = 1'b0;
            close_grammar_loop(ln);
        end else if (fn == FN_TAG) begin
            st_free_tl = ln;
            if (st_loop) begin
                if (st_hdr) begin
                    if (st_tags < MAX_TAGS) begin
                        st_tag_ln[st_tags] = ln;
                        st_tags++;
                    end else begin
                        add_event(EV_ERROR, DG_TAG_OVF, ln, 0, '0, 1'b0, '0);
                    end
                end else begin
                    st_loop = 1'b0;
                    close_grammar_loop(ln);
                    st_pend = 1'b1;
                end
            end else begin
                if (st_pend)
                    add_event(EV_ERROR, DG_VAL_EXP, ln, 0, '0, 1'b0, '0);
                st_pend = 1'b1;
            end
        end else if (fn >= FN_VAL_SQ && fn <= FN_VAL_BV) begin
            if (st_loop) begin
                if (st_tags < 1)
                    add_event(EV_ERROR, DG_NO_TAGS, ln, 0, '0, 1'b0, '0);
                st_hdr = 1'b0;
                if (st_vals < int'(VT_MAX))
                    st_vals++;
                st_col++;
                if (st_col >= st_tags) begin
                    if (st_row < longint'(ln)) begin
                        if (st_wrap < 0)
                            st_wrap = longint'(ln);
                        st_row = longint'(ln);
                    end
                    st_col = 0;
                end
            end else begin
                if (!st_pend)
                    add_event(EV_ERROR, DG_VAL_UNEXP, ln, 0, '0, 1'b0, '0);
                st_pend = 1'b0;
            end
            if (kw)
                add_event(EV_WARNING, DG_KEYWORD, ln, 0, '0, 1'b0, '0);
            if (st_loop) begin
                col = (st_col < 0) ? 0 : st_col;
                tl = (col < st_tags && col < MAX_TAGS) ? st_tag_ln[col] : '0;
                add_event(EV_VALUE, DG_NONE, ln, col, tl, 1'b1, KIND_W'(fn - FN_VAL_SQ));
            end else begin
                add_event(EV_VALUE, DG_NONE, ln, 0, st_free_tl, 1'b0,
                          KIND_W'(fn - FN_VAL_SQ));
            end
        end else begin
            add_event(EV_ERROR, (fn == FN_DATA) ? DG_DATA_AGAIN : DG_BAD_KIND,
                      ln, 0, '0, 1'b0, '0);
        end
        if (grammar_events_q.size() > first)
            grammar_events_q[grammar_events_q.size() - 1].last = 1'b1;
    endtask

    function automatic int roll_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 25;
            default: return 60;
        endcase
    endfunction

    function automatic bit rnd_kw();
        return $urandom_range(0, 7) == 0;
    endfunction

    function automatic logic [FUNC_W-1:0] rnd_value();
        return FN_VAL_SQ + FUNC_W'($urandom_range(0, 4));
    endfunction

    task automatic queue_token(logic [FUNC_W-1:0] fn, logic kw);
        t_token t;
        t.fn = fn;
        t.ln = cur_ln;
        t.kw = kw;
        t.hold = hold_next;
        hold_next = 1'b0;
        pending_tokens = {pending_tokens, t};
    endtask

    task automatic queue_loop(int nt, int nv);
        queue_token(FN_LOOP, rnd_kw());
        for (int i = 0; i < nt; i++) begin
            cur_ln += LINE_BITS'($urandom_range(0, 1));
            queue_token(FN_TAG, rnd_kw());
        end
        for (int i = 0; i < nv; i++) begin
            if (nt == 0 || i % nt == 0)
                cur_ln += LINE_BITS'($urandom_range(0, 2));
            if ($urandom_range(0, 15) == 0)
                queue_token(FN_COMM, rnd_kw());
            queue_token(rnd_value(), rnd_kw());
        end
        case ($urandom_range(0, 5))
            0, 1, 2: queue_token(FN_STOP, rnd_kw());
            3: begin
                cur_ln++;
                queue_token(FN_TAG, rnd_kw());
                queue_token(rnd_value(), rnd_kw());
            end
            4: ;
            default: queue_token(FN_DATA, rnd_kw());
        endcase
    endtask

    // token driver
    always @(posedge i_clk) begin : tx_drive
        bit busy;
        t_token nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                track_grammar(s_tuser[FUNC_W-1:0], s_tdata, s_tuser[FUNC_W]);
                tokens_taken++;
                busy = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                tx_pct = pick_pct();
            if (!busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_tokens.size() != 0 &&
                             !(pending_tokens[0].hold && grammar_events_q.size() != 0)) begin
                    nxt = pending_tokens.pop_front();
                    s_tdata <= nxt.ln;
                    s_tuser <= {nxt.kw, nxt.fn};
                    busy = 1'b1;
                    tx_gap = roll_gap(tx_pct);
                end
            end
            s_tvalid <= busy;
        end
    end

    task automatic check_field(string fname, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // event word monitor
    always @(posedge i_clk) begin : rx_mon
        t_gram_event want;
        t_gram_event got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.code = m_tdata[3:0];
                got.ln = m_tdata[27:4];
                got.col = m_tdata[33:28];
                got.tl = m_tdata[57:34];
                got.ev = m_tuser[3:0];
                got.looped = m_tuser[4];
                got.kind = m_tuser[7:5];
                got.last = m_tlast;
                words_seen++;
                if (got.ev < 9)
                    ev_hits[got.ev]++;
                if (grammar_events_q.size() == 0) begin
                    $error("event word with no event pending: event_res %0d line %0d",
                           got.ev, got.ln);
                    fail_cnt++;
                end else begin
                    want = grammar_events_q.pop_front();
                    check_field("event_res", want.ev, got.ev);
                    check_field("code", want.code, got.code);
                    check_field("event_line", want.ln, got.ln);
                    check_field("column", want.col, got.col);
                    check_field("tag_line", want.tl, got.tl);
                    check_field("looped", want.looped, got.looped);
                    check_field("value_kind", want.kind, got.kind);
                    check_field("last", want.last, got.last);
                end
                if (words_seen == 40 && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    rx_stall = 300;
                end
            end
            if ($urandom_range(0, 199) == 0)
                rx_pct = pick_pct();
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = roll_gap(rx_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("star_loop_grammar_checker_core regression: fail");
            $finish;
        end
    end

    initial begin
        int base;
        int nt;
        int nv;
        bit ovf_done;
        logic [FUNC_W-1:0] halt_fn;
        ovf_done = 1'b0;

        // file level
        cur_ln = '0;
        queue_token(FN_COMM, 1'b0);
        cur_ln = '1;
        queue_token(FN_LOOP, 1'b1);
        cur_ln = 24'd1;
        queue_token(FN_STOP, 1'b0);
        cur_ln++;
        queue_token(FN_TAG, 1'b0);
        cur_ln++;
        queue_token(FN_VAL_BV, 1'b1);
        queue_token(4'd12, 1'b0);
        queue_token(4'd15, 1'b1);
        cur_ln = '0;
        queue_token(FN_DATA, 1'b0);
        // data block
        cur_ln = 24'd10;
        queue_token(FN_DATA, 1'b1);
        queue_token(FN_VAL_SQ, 1'b0);
        cur_ln++;
        queue_token(FN_TAG, 1'b0);
        cur_ln++;
        queue_token(FN_TAG, 1'b0);
        queue_token(FN_VAL_DQ, 1'b1);
        cur_ln++;
        queue_token(FN_STOP, 1'b0);
        queue_token(FN_LOOP, 1'b0);
        queue_token(FN_VAL_SC, 1'b1);
        queue_token(FN_STOP, 1'b0);
        cur_ln++;
        queue_token(FN_LOOP, 1'b0);
        cur_ln++;
        queue_token(FN_TAG, 1'b0);
        cur_ln++;
        queue_token(FN_TAG, 1'b0);
        cur_ln++;
        queue_token(FN_VAL_FC, 1'b0);
        queue_token(FN_VAL_BV, 1'b0);
        cur_ln++;
        queue_token(FN_VAL_SQ, 1'b0);
        cur_ln++;
        queue_token(FN_STOP, 1'b0);
        queue_token(FN_TAG, 1'b0);
        queue_token(FN_LOOP, 1'b0);
        queue_token(4'd13, 1'b1);

        base = pending_tokens.size();
        while (pending_tokens.size() < base + 90) begin
            if (!ovf_done && pending_tokens.size() >= base + 10) begin
                // sender waits for all events, then a loop past the tag limit
                ovf_done = 1'b1;
                hold_next = 1'b1;
                queue_loop(MAX_TAGS + $urandom_range(1, 2), $urandom_range(2, 6));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    nt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                    nv = $urandom_range(0, 4) * nt;
                    if (nt == 0 || $urandom_range(0, 3) == 0)
                        nv += $urandom_range(0, 3);
                    queue_loop(nt, nv);
                end
                5, 6: begin
                    cur_ln++;
                    queue_token(FN_TAG, rnd_kw());
                    if ($urandom_range(0, 3) != 0)
                        queue_token(rnd_value(), rnd_kw());
                end
                7, 8: begin
                    if ($urandom_range(0, 2) == 0)
                        cur_ln = LINE_BITS'($urandom);
                    else
                        cur_ln += LINE_BITS'($urandom_range(0, 2));
                    queue_token(FUNC_W'($urandom_range(2, 15)), 1'($urandom_range(0, 1)));
                end
                default: queue_token(FN_COMM, rnd_kw());
            endcase
        end

        // halt, then tokens that must give nothing
        halt_fn = ($urandom_range(0, 1) == 0) ? FN_END : FN_LEXERR;
        cur_ln++;
        hold_next = 1'b1;
        queue_token(halt_fn, rnd_kw());
        queue_token(FN_VAL_BV, 1'b1);
        queue_token(FN_END, 1'b0);
        queue_token(FN_LEXERR, 1'b0);
        queue_token(FN_TAG, 1'b0);
        tokens_total = pending_tokens.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tokens_taken < tokens_total)
            @(posedge i_clk);
        while (grammar_events_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d tokens, %0d event words: %0d values, %0d errors, %0d warnings, %0d loops",
                 tokens_total, words_seen, ev_hits[EV_VALUE], ev_hits[EV_ERROR],
                 ev_hits[EV_WARNING], ev_hits[EV_STARTLOOP]);
        $display("tag overflow loop, long output hold-off, halt by %s with later tokens dropped",
                 (halt_fn == FN_END) ? "end of input" : "lexer error");
        if (fail_cnt == 0)
            $display("star_loop_grammar_checker_core regression: pass");
        else
            $display("star_loop_grammar_checker_core regression: fail");
        $finish;
    end

endmodule
